@@ rtl/bdq_pkg.sv @@
package bdq_pkg;

  localparam int CMD_W  = 3;
  localparam int CAP_W  = 7;
  localparam int OUT_W  = 32;
  localparam int ADDR_W = 3;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic shift_right;
    logic shift_left;
    logic write_rear;
    logic drop_rear;
  } cell_op_t;

endpackage

@@ rtl/bdq_if.sv @@
interface bdq_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] value;

  modport source(output valid, command, value, input ready);
  modport sink(input valid, command, value, output ready);
endinterface

interface bdq_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;
  logic [6:0]         entry_count;
  logic               is_empty;
  logic               is_full;

  modport source(output valid, ok, front_value, rear_value, entry_count, is_empty, is_full,
                 input ready);
  modport sink(input valid, ok, front_value, rear_value, entry_count, is_empty, is_full,
               output ready);
endinterface

@@ rtl/bdq_cell.sv @@
module bdq_cell #(
  parameter int WORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bdq_pkg::cell_op_t     op,
  input  logic [WORD_WIDTH-1:0] push_word,
  input  logic [WORD_WIDTH-1:0] left_word,
  input  logic                  left_valid,
  input  logic [WORD_WIDTH-1:0] right_word,
  input  logic                  right_valid,
  output logic [WORD_WIDTH-1:0] word,
  output logic                  valid,
  output logic                  is_rear
);
  import bdq_pkg::*;

  logic first_free;

  assign first_free = left_valid && !valid;
  assign is_rear    = valid && !right_valid;

  always_ff @(posedge clk) begin
    if (op.shift_right) begin
      word <= left_word;
    end else if (op.shift_left) begin
      word <= right_word;
    end else if (op.write_rear && first_free) begin
      word <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (op.shift_right) begin
      valid <= left_valid;
    end else if (op.shift_left) begin
      valid <= right_valid;
    end else if (op.write_rear && first_free) begin
      valid <= 1'b1;
    end else if (op.drop_rear && is_rear) begin
      valid <= 1'b0;
    end
  end

endmodule

@@ rtl/bounded_double_ended_queue.sv @@
// A request's outcome is held in calc, ok and count, then registered into the
// rsp outputs and shown on rsp.valid from then on. req.ready is low while
// calc is set and while a result waits on rsp.ready; the row of cells shifts
// in the accept cycle and the rear entry is picked from the row in the next one.
// Reset (synchronous, active high) empties the row, clears the count and
// sets capacity to 64; held words are not cleared.
module bounded_double_ended_queue #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  bdq_req_if.sink     req,
  bdq_rsp_if.source   rsp
);
  import bdq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int EXT_W = (WORD_WIDTH > OUT_W) ? WORD_WIDTH : OUT_W;

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  ok;
  logic                  ok_next;
  logic                  calc;
  logic                  out_valid;
  logic                  accept;
  logic                  full_now;
  logic                  empty_now;
  logic [CMP_W-1:0]      cap_eff;
  cell_op_t              op;
  cell_op_t              op_next;
  logic [WORD_WIDTH-1:0] push_word;
  logic [EXT_W-1:0]      push_ext;
  logic [WORD_WIDTH-1:0] words [DEPTH];
  logic [DEPTH-1:0]      valids;
  logic [DEPTH-1:0]      rear_sel;
  logic [WORD_WIDTH-1:0] rear_word;
  logic [EXT_W-1:0]      front_ext;
  logic [EXT_W-1:0]      rear_ext;
  logic                  empty_after;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  assign cap_eff   = (CMP_W'(capacity) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(capacity);
  assign full_now  = CMP_W'(count) >= cap_eff;
  assign empty_now = count == '0;

  assign req.ready = !calc && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign push_ext  = EXT_W'($unsigned(req.value));
  assign push_word = push_ext[WORD_WIDTH-1:0];

  always_comb begin
    op_next    = '0;
    ok_next    = 1'b0;
    count_next = count;
    case (req.command)
      CMD_PUSH_FRONT: begin
        if (!full_now) begin
          op_next.shift_right = 1'b1;
          ok_next             = 1'b1;
          count_next          = count + CNT_W'(1);
        end
      end
      CMD_PUSH_REAR: begin
        if (!full_now) begin
          op_next.write_rear = 1'b1;
          ok_next            = 1'b1;
          count_next         = count + CNT_W'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (!empty_now) begin
          op_next.shift_left = 1'b1;
          ok_next            = 1'b1;
          count_next         = count - CNT_W'(1);
        end
      end
      CMD_POP_REAR: begin
        if (!empty_now) begin
          op_next.drop_rear = 1'b1;
          ok_next           = 1'b1;
          count_next        = count - CNT_W'(1);
        end
      end
      CMD_QUERY: begin
        ok_next = 1'b1;
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
  end

  assign op = accept ? op_next : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      calc  <= 1'b0;
    end else begin
      calc <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ok <= ok_next;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_word;
    logic                  left_valid;
    logic [WORD_WIDTH-1:0] right_word;
    logic                  right_valid;

    if (g == 0) begin : g_head
      assign left_word  = push_word;
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_word  = words[g-1];
      assign left_valid = valids[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_word  = '0;
      assign right_valid = 1'b0;
    end else begin : g_body
      assign right_word  = words[g+1];
      assign right_valid = valids[g+1];
    end

    bdq_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .op         (op),
      .push_word  (push_word),
      .left_word  (left_word),
      .left_valid (left_valid),
      .right_word (right_word),
      .right_valid(right_valid),
      .word       (words[g]),
      .valid      (valids[g]),
      .is_rear    (rear_sel[g])
    );
  end

  always_comb begin
    rear_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_word = rear_word | (rear_sel[i] ? words[i] : '0);
    end
  end

  assign front_ext   = EXT_W'($signed(words[0]));
  assign rear_ext    = EXT_W'($signed(rear_word));
  assign empty_after = count == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (calc) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (calc) begin
      rsp.ok          <= ok;
      rsp.front_value <= empty_after ? '1 : $signed(front_ext[OUT_W-1:0]);
      rsp.rear_value  <= empty_after ? '1 : $signed(rear_ext[OUT_W-1:0]);
      rsp.entry_count <= CAP_W'(count);
      rsp.is_empty    <= empty_after;
      rsp.is_full     <= CMP_W'(count) >= cap_eff;
    end
  end

  assign rsp.valid = out_valid;

endmodule

@@ rtl/bdq_chk.sv @@
module bdq_chk (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               ok,
  input logic signed [31:0] front_value,
  input logic signed [31:0] rear_value,
  input logic [6:0]         entry_count,
  input logic               is_empty,
  input logic               is_full
);

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == 7'd0)))
    else $error("empty flag disagrees with count");

  a_empty_words: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> (front_value == -32'sd1) && (rear_value == -32'sd1))
    else $error("empty queue shows a word");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready ##1 rsp_valid)
    else $error("request overlaps one in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(ok) && $stable(entry_count)
      && $stable(front_value) && $stable(rear_value) && $stable(is_full))
    else $error("stalled result changed");

endmodule

bind bounded_double_ended_queue bdq_chk u_bdq_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .ok         (rsp.ok),
  .front_value(rsp.front_value),
  .rear_value (rsp.rear_value),
  .entry_count(rsp.entry_count),
  .is_empty   (rsp.is_empty),
  .is_full    (rsp.is_full)
);
